// ===== sv/nret_pkg.sv =====
// shared constants and types for the nearest reachable endpoint table
`timescale 1ns / 1ps

package nret_pkg;

	localparam int ROUTE_CAPACITY = 1024;
	localparam int IDX_W = $clog2(ROUTE_CAPACITY);
	localparam int CNT_W = $clog2(ROUTE_CAPACITY + 1);
	localparam int STN_W = 32;
	localparam int PAIR_W = 2 * STN_W;

	localparam logic MODE_ADD = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef logic [STN_W-1:0] stn_t;
	typedef logic [PAIR_W-1:0] pair_t;

	typedef struct packed {
		logic valid;
		stn_t station;
	} cand_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

endpackage

// ===== sv/nret_route_mem.sv =====
// route pair storage, one write port and one registered read port
`timescale 1ns / 1ps

module nret_route_mem (
	input logic clk,
	input logic wr_en,
	input logic [nret_pkg::IDX_W-1:0] wr_addr,
	input nret_pkg::pair_t wr_data,
	input logic [nret_pkg::IDX_W-1:0] rd_addr,
	output nret_pkg::pair_t rd_data
);
	import nret_pkg::*;

	pair_t mem_q [ROUTE_CAPACITY];
	pair_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== sv/nret_dist_unit.sv =====
// shared absolute distance and running minimum unit
`timescale 1ns / 1ps

module nret_dist_unit (
	input logic clk,
	input logic arst_n,
	input logic clr,
	input nret_pkg::cand_t cand,
	input nret_pkg::stn_t target,
	output logic pending,
	output nret_pkg::stn_t best
);
	import nret_pkg::*;

	logic [STN_W:0] diff;
	logic [STN_W:0] neg;
	stn_t absd;
	stn_t absd_s1;
	logic valid_s1;
	stn_t best_q;

	always_comb begin
		diff = {cand.station[STN_W-1], cand.station} - {target[STN_W-1], target};
		neg = ~diff + 1'b1;
		absd = diff[STN_W] ? neg[STN_W-1:0] : diff[STN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cand.valid;
		end
	end

	always_ff @(posedge clk) begin
		absd_s1 <= absd;
		if (clr) begin
			best_q <= '1;
		end else if (valid_s1 && (absd_s1 < best_q)) begin
			best_q <= absd_s1;
		end
	end

	assign pending = valid_s1;
	assign best = best_q;

endmodule

// ===== sv/nearest_reachable_endpoint_table.sv =====
// top level: sequencer scanning the route table through the shared distance unit
//
//  channel   ports                                   transfer
//  input     start, busy, mode, start_req, finish    start & !busy
//  result    done, distance, table_full              done, one cycle, no stall
//
// a query or an add scans every stored pair through the single memory read port, one stored
// pair per cycle in ST_SCAN, waits in ST_DRAIN until the read and distance pipeline is empty,
// then passes ST_FINISH, from which done is registered
// reset clears the sequencer and the route count; pairs are not cleared
// busy stays high from the transfer until the cycle before done
// the receiver cannot stall; done is a single-cycle strobe
`timescale 1ns / 1ps

module nearest_reachable_endpoint_table (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic mode,
	input logic signed [nret_pkg::STN_W-1:0] start_req,
	input logic signed [nret_pkg::STN_W-1:0] finish,
	output logic done,
	output logic [nret_pkg::STN_W-1:0] distance,
	output logic table_full
);
	import nret_pkg::*;

	state_t state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_q;
	logic mode_q;
	stn_t a_q;
	stn_t b_q;
	logic init_q;
	logic found_q;
	logic rd_valid_s1;
	logic done_q;
	stn_t distance_q;
	logic full_q;

	logic accept;
	logic rd_issue;
	logic wr_en;
	pair_t rd_data;
	pair_t fwd;
	pair_t rev;
	stn_t hi;
	stn_t lo;
	cand_t cand;
	logic unit_pending;
	stn_t best;

	assign accept = start && (state_q == ST_IDLE);
	assign busy = (state_q != ST_IDLE);
	assign rd_issue = (state_q == ST_SCAN) && (idx_q != count_q);
	assign fwd = {a_q, b_q};
	assign rev = {b_q, a_q};
	assign hi = rd_data[PAIR_W-1:STN_W];
	assign lo = rd_data[STN_W-1:0];
	assign wr_en = (state_q == ST_FINISH) && (mode_q == MODE_ADD) && !found_q
		&& (count_q != CNT_W'(ROUTE_CAPACITY));

	always_comb begin
		if (init_q) begin
			cand.valid = (mode_q == MODE_QUERY);
			cand.station = a_q;
		end else begin
			cand.valid = rd_valid_s1 && (mode_q == MODE_QUERY) && ((hi == a_q) || (lo == a_q));
			cand.station = (hi == a_q) ? lo : hi;
		end
	end

	nret_route_mem u_mem (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(count_q[IDX_W-1:0]),
		.wr_data(fwd),
		.rd_addr(idx_q[IDX_W-1:0]),
		.rd_data(rd_data)
	);

	nret_dist_unit u_dist (
		.clk(clk),
		.arst_n(arst_n),
		.clr(accept),
		.cand(cand),
		.target(b_q),
		.pending(unit_pending),
		.best(best)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			idx_q <= '0;
			init_q <= 1'b0;
			found_q <= 1'b0;
			rd_valid_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_FINISH);
			init_q <= accept;
			rd_valid_s1 <= rd_issue;
			if (accept) begin
				found_q <= 1'b0;
			end else if (rd_valid_s1 && (mode_q == MODE_ADD)
				&& ((rd_data == fwd) || (rd_data == rev))) begin
				found_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SCAN;
						idx_q <= '0;
					end
				end
				ST_SCAN: begin
					if (rd_issue) begin
						idx_q <= idx_q + 1'b1;
					end
					if ((idx_q + 1'b1 == count_q) || (idx_q == count_q)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!rd_valid_s1 && !unit_pending && !init_q) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					state_q <= ST_IDLE;
					if (wr_en) begin
						count_q <= count_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			a_q <= start_req;
			b_q <= finish;
		end
		if (state_q == ST_FINISH) begin
			distance_q <= (mode_q == MODE_QUERY) ? best : '0;
			full_q <= (mode_q == MODE_ADD) && !found_q
				&& (count_q == CNT_W'(ROUTE_CAPACITY));
		end
	end

	assign done = done_q;
	assign distance = distance_q;
	assign table_full = full_q;

endmodule

// ===== sim/tb_top.sv =====
// testbench for the nearest reachable endpoint table: directed and random checks
`timescale 1ns / 1ps

module tb_top;
	import nret_pkg::*;

	localparam stn_t STN_MIN = 32'h8000_0000;
	localparam stn_t STN_MAX = 32'h7fff_ffff;
	localparam int POOL_SIZE = 24;
	localparam int ANSWER_DEPTH = 8;

	typedef struct packed {
		stn_t distance;
		logic table_full;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic mode = MODE_ADD;
	stn_t start_req = '0;
	stn_t finish = '0;
	logic done;
	stn_t distance;
	logic table_full;

	pair_t route_book [ROUTE_CAPACITY];
	int unsigned route_total = 0;
	answer_t answer_ring [ANSWER_DEPTH];
	int unsigned answers_sent = 0;
	int unsigned answers_checked = 0;
	int mismatch_count = 0;

	nearest_reachable_endpoint_table u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.start_req(start_req),
		.finish(finish),
		.done(done),
		.distance(distance),
		.table_full(table_full)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#80ms;
		$display("Test completed with failures");
		$finish;
	end

	function automatic longint unsigned station_gap(stn_t a, stn_t b);
		longint sa;
		longint sb;
		sa = $signed(a);
		sb = $signed(b);
		return (sa >= sb) ? longint'(sa - sb) : longint'(sb - sa);
	endfunction

	// applies one item to the shadow table and returns the answer it must produce
	function automatic answer_t route_answer(logic m, stn_t a, stn_t b);
		answer_t ans;
		logic found;
		longint unsigned best;
		longint unsigned d;
		int i;
		ans.distance = '0;
		ans.table_full = 1'b0;
		if (m == MODE_ADD) begin
			found = 1'b0;
			for (i = 0; i < route_total; i++)
				if (route_book[i] == {a, b} || route_book[i] == {b, a})
					found = 1'b1;
			if (!found) begin
				if (route_total < ROUTE_CAPACITY) begin
					route_book[route_total] = {a, b};
					route_total++;
				end else begin
					ans.table_full = 1'b1;
				end
			end
		end else begin
			best = station_gap(a, b);
			for (i = 0; i < route_total; i++) begin
				if (route_book[i][PAIR_W-1:STN_W] == a) begin
					d = station_gap(route_book[i][STN_W-1:0], b);
					if (d < best)
						best = d;
				end
				if (route_book[i][STN_W-1:0] == a) begin
					d = station_gap(route_book[i][PAIR_W-1:STN_W], b);
					if (d < best)
						best = d;
				end
			end
			ans.distance = best[STN_W-1:0];
		end
		return ans;
	endfunction

	// start is left high after the transfer; the next call with a nonzero gap or the end of the run lowers it
	task automatic send_item(input logic m, input stn_t a, input stn_t b, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			if ($urandom_range(0, 1) == 1) begin
				@(posedge clk);
				while (busy)
					@(posedge clk);
			end
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		mode <= m;
		start_req <= a;
		finish <= b;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		answer_ring[answers_sent % ANSWER_DEPTH] = route_answer(m, a, b);
		answers_sent++;
	endtask

	always @(posedge clk) begin : check_results
		answer_t want;
		if (arst_n && done) begin
			if (answers_checked == answers_sent) begin
				if (mismatch_count < 10)
					$display("unexpected result: distance %h table_full %b", distance, table_full);
				mismatch_count++;
			end else begin
				want = answer_ring[answers_checked % ANSWER_DEPTH];
				answers_checked++;
				if (distance !== want.distance) begin
					if (mismatch_count < 10)
						$display("distance mismatch: expected %h actual %h",
							want.distance, distance);
					mismatch_count++;
				end
				if (table_full !== want.table_full) begin
					if (mismatch_count < 10)
						$display("table_full mismatch: expected %b actual %b",
							want.table_full, table_full);
					mismatch_count++;
				end
			end
		end
	end

	task automatic test_empty_table();
		send_item(MODE_QUERY, STN_MIN, STN_MAX, 0);
		send_item(MODE_QUERY, STN_MAX, STN_MIN, 0);
		send_item(MODE_QUERY, 32'd0, 32'd0, 2);
	endtask

	task automatic test_route_adds();
		send_item(MODE_ADD, 32'd5, 32'd100, 0);
		send_item(MODE_ADD, 32'd100, 32'd5, 0);
		send_item(MODE_ADD, 32'd5, 32'd100, 3);
		send_item(MODE_ADD, 32'd5, -32'sd7, 0);
		send_item(MODE_ADD, STN_MIN, STN_MAX, 0);
		send_item(MODE_ADD, 32'd9, 32'd9, 0);
		send_item(MODE_ADD, 32'd9, 32'd9, 1);
		send_item(MODE_ADD, 32'hffff_ffff, 32'd0, 0);
	endtask

	task automatic test_nearest_queries();
		send_item(MODE_QUERY, 32'd5, 32'd98, 0);
		send_item(MODE_QUERY, 32'd100, 32'd6, 0);
		send_item(MODE_QUERY, 32'd5, -32'sd8, 0);
		send_item(MODE_QUERY, 32'd9, 32'd20, 4);
		send_item(MODE_QUERY, 32'd9, 32'd9, 0);
		send_item(MODE_QUERY, STN_MIN, STN_MAX - 32'd1, 0);
		send_item(MODE_QUERY, STN_MAX, STN_MIN, 0);
		send_item(MODE_QUERY, 32'hffff_ffff, 32'd3, 0);
		send_item(MODE_QUERY, 32'd0, 32'hffff_ffff, 0);
		send_item(MODE_QUERY, 32'd12345, 32'd0, 0);
	endtask

	// small station pool so adds repeat often and queries mostly hit stored routes
	task automatic test_random_traffic();
		stn_t pool [POOL_SIZE];
		stn_t a;
		stn_t b;
		logic m;
		int gap;
		int i;
		int k;
		pool[0] = STN_MIN;
		pool[1] = STN_MAX;
		pool[2] = 32'd0;
		pool[3] = 32'hffff_ffff;
		for (i = 4; i < POOL_SIZE; i++)
			pool[i] = ($urandom_range(0, 1) == 1) ? stn_t'($urandom) :
				stn_t'(int'($urandom_range(0, 200)) - 100);
		for (k = 0; k < 560; k++) begin
			if ($urandom_range(0, 9) < 4) begin
				m = MODE_ADD;
				if ($urandom_range(0, 9) < 8) begin
					a = pool[$urandom_range(0, POOL_SIZE - 1)];
					b = pool[$urandom_range(0, POOL_SIZE - 1)];
				end else begin
					a = $urandom;
					b = ($urandom_range(0, 1) == 1) ? stn_t'($urandom) :
						pool[$urandom_range(0, POOL_SIZE - 1)];
				end
			end else begin
				m = MODE_QUERY;
				a = ($urandom_range(0, 9) < 8) ? pool[$urandom_range(0, POOL_SIZE - 1)] :
					stn_t'($urandom);
				case ($urandom_range(0, 2))
					0: b = pool[$urandom_range(0, POOL_SIZE - 1)] +
						stn_t'(int'($urandom_range(0, 20)) - 10);
					1: b = $urandom;
					default: b = ($urandom_range(0, 1) == 1) ? STN_MIN : STN_MAX;
				endcase
			end
			gap = 0;
			if (k < 480 && (k / 40) % 2 == 0 && $urandom_range(0, 2) == 0)
				gap = $urandom_range(1, 14);
			send_item(m, a, b, gap);
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_empty_table();
		test_route_adds();
		test_nearest_queries();
		test_random_traffic();
		start <= 1'b0;
		@(posedge clk);
		while (answers_checked != answers_sent)
			@(posedge clk);
		repeat (ROUTE_CAPACITY + 16) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
